[src/lfra_pkg.sv]
package lfra_pkg;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_DEPART = 1'b1;

    // free-map bits examined per scan cycle
    localparam int SCAN_W = 32;

    typedef struct packed {
        logic       action;
        logic [7:0] customer;
    } t_in;

    typedef struct packed {
        logic [8:0] room;
        logic [7:0] customer_out;
        logic [8:0] occupancy;
        logic [8:0] peak_occupancy;
        logic       no_room;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic alloc;
        logic rel;
        logic set_full;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_ok;
        logic in_depart;
        logic rel_ok;
        logic chunk_hit;
        logic chunk_last;
        logic out_free;
    } t_sts;

endpackage

[src/lfra_ram.sv]
module lfra_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/lfra_ctrl.sv]
module lfra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lfra_pkg::t_sts  i_sts,
    output lfra_pkg::t_cmd  o_cmd
);

    lfra_pkg::t_state r_state;
    lfra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lfra_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_ok) begin
                        n_state = lfra_pkg::S_DONE;
                    end else if (i_sts.in_depart) begin
                        n_state = lfra_pkg::S_READ;
                    end else begin
                        n_state = lfra_pkg::S_SCAN;
                    end
                end
            end
            lfra_pkg::S_READ: begin
                o_cmd.rel = i_sts.rel_ok;
                n_state   = lfra_pkg::S_DONE;
            end
            lfra_pkg::S_SCAN: begin
                if (i_sts.chunk_hit) begin
                    o_cmd.alloc = 1'b1;
                    n_state     = lfra_pkg::S_DONE;
                end else if (i_sts.chunk_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = lfra_pkg::S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            lfra_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = lfra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lfra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[src/lfra_dp.sv]
module lfra_dp #(
    parameter int ROOMS     = 256,
    parameter int CUSTOMERS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lfra_pkg::t_cmd  i_cmd,
    output lfra_pkg::t_sts  o_sts,
    input  lfra_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lfra_pkg::t_out  o_out_data
);

    localparam int RW  = $clog2(ROOMS + 1);
    localparam int FW  = $clog2(ROOMS);
    localparam int AW  = $clog2(CUSTOMERS);
    localparam int CXW = (AW > 8) ? AW : 8;
    localparam int CW  = (ROOMS < lfra_pkg::SCAN_W) ? ROOMS : lfra_pkg::SCAN_W;
    localparam int EW  = $clog2(CW);
    localparam int NCH = (ROOMS + CW - 1) / CW;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

    logic [ROOMS-1:0]   r_free;
    logic [RW-1:0]      r_in_use;
    logic [RW-1:0]      r_peak;
    logic               r_out_valid;
    lfra_pkg::t_out     r_out;

    logic               r_act;
    logic [7:0]         r_cust;
    logic [RW-1:0]      r_room;
    logic               r_full;
    logic [CHW-1:0]     r_chunk;

    logic [CXW-1:0]     in_cust_x;
    logic [CXW-1:0]     r_cust_x;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [RW-1:0]      wdata;
    logic [RW-1:0]      held;
    logic [RW-1:0]      held_m1;
    logic [FW-1:0]      held_idx;
    logic               rel_ok;

    logic [NCH*CW-1:0]  free_pad;
    logic [CW-1:0]      chunk_bits;
    logic [EW-1:0]      enc;
    logic               hit;
    logic [RW-1:0]      slot;
    logic [RW-1:0]      room_new;
    logic [RW-1:0]      in_use_inc;

    assign in_cust_x = CXW'(i_in_data.customer);
    assign r_cust_x  = CXW'(r_cust);
    assign raddr     = i_cmd.load ? in_cust_x[AW-1:0] : r_cust_x[AW-1:0];
    assign waddr     = r_cust_x[AW-1:0];
    assign wdata     = i_cmd.alloc ? room_new : '0;

    lfra_ram #(
        .WIDTH (RW),
        .DEPTH (CUSTOMERS)
    ) u_held (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc | i_cmd.rel),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (held)
    );

    // departure: recorded room must be in range and currently taken
    assign held_m1  = held - RW'(1);
    assign held_idx = held_m1[FW-1:0];
    assign rel_ok   = (held != '0) && ({1'b0, held} <= (RW + 1)'(ROOMS))
                      && !r_free[held_idx];

    // lowest free bit of the current chunk; padding bits read as taken
    assign free_pad   = (NCH * CW)'(r_free);
    assign chunk_bits = free_pad[r_chunk * CW +: CW];

    always_comb begin
        enc = '0;
        hit = 1'b0;
        for (int i = CW - 1; i >= 0; i--) begin
            if (chunk_bits[i]) begin
                enc = EW'(i);
                hit = 1'b1;
            end
        end
    end

    assign slot       = RW'(r_chunk) * RW'(CW) + RW'(enc);
    assign room_new   = slot + RW'(1);
    assign in_use_inc = r_in_use + RW'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.in_ok      = ({1'b0, in_cust_x} < (CXW + 1)'(CUSTOMERS));
        o_sts.in_depart  = (i_in_data.action == lfra_pkg::ACT_DEPART);
        o_sts.rel_ok     = rel_ok && (r_act == lfra_pkg::ACT_DEPART);
        o_sts.chunk_hit  = hit;
        o_sts.chunk_last = (r_chunk == CHW'(NCH - 1));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= '1;
            r_in_use    <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.alloc) begin
                r_free[slot[FW-1:0]] <= 1'b0;
                r_in_use             <= in_use_inc;
                if (in_use_inc > r_peak) begin
                    r_peak <= in_use_inc;
                end
            end
            if (i_cmd.rel) begin
                r_free[held_idx] <= 1'b1;
                if (r_in_use != '0) begin
                    r_in_use <= r_in_use - RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_in_data.action;
            r_cust  <= i_in_data.customer;
            r_room  <= '0;
            r_full  <= 1'b0;
            r_chunk <= '0;
        end
        if (i_cmd.scan_next) begin
            r_chunk <= r_chunk + CHW'(1);
        end
        if (i_cmd.alloc) begin
            r_room <= room_new;
        end
        if (i_cmd.rel) begin
            r_room <= held;
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.room           <= 9'(r_room);
            r_out.customer_out   <= r_cust;
            r_out.occupancy      <= 9'(r_in_use);
            r_out.peak_occupancy <= 9'(r_peak);
            r_out.no_room        <= r_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[src/lowest_free_room_allocator.sv]
// Lowest-free room allocator.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries time-ordered
// arrival and departure events; one transaction per event. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns one result per event:
// room granted or freed, echoed customer, occupancy, peak and no_room flag.
// From an accepted event to o_out_valid: a departure reads its record
// from the customer table, then releases the room; a customer index out
// of range goes straight to the result; an arrival scans the free map in
// 32-room slices until a free room is found (1 to ceil(ROOMS/32) slices,
// 8 at the default size). The slice scan sets the arrival time; the
// table's registered read sets the departure time.
// Events are handled one at a time: the next event is taken the cycle
// after the previous result is loaded into the output register.
// A new event is accepted while a result still waits in the output
// register; its result is held until i_out_stall drops, and the block
// accepts nothing more meanwhile.
// Reset (synchronous, active low) frees all rooms and clears occupancy
// and peak; the customer table is not cleared.
module lowest_free_room_allocator #(
    parameter int ROOMS     = 256,
    parameter int CUSTOMERS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lfra_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lfra_pkg::t_out  o_out_data
);

    lfra_pkg::t_cmd cmd;
    lfra_pkg::t_sts sts;

    lfra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfra_dp #(
        .ROOMS     (ROOMS),
        .CUSTOMERS (CUSTOMERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[test/lfra_checker.sv]
`timescale 1ns / 100ps

module lfra_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  lfra_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  lfra_pkg::t_out i_out_data,
    output int             o_mismatches,
    output int             o_outstanding
);

    localparam int ROOM_COUNT     = 256;
    localparam int CUSTOMER_COUNT = 256;

    // predictor state: 1 = room vacant
    logic [ROOM_COUNT-1:0] vacant = '1;
    logic [8:0]            room_of [CUSTOMER_COUNT];
    logic [8:0]            rooms_busy = '0;
    logic [8:0]            busiest = '0;
    lfra_pkg::t_out        booking_q[$];

    initial begin
        for (int c = 0; c < CUSTOMER_COUNT; c++) begin
            room_of[c] = '0;
        end
    end

    function automatic lfra_pkg::t_out settle_event(lfra_pkg::t_in ev);
        lfra_pkg::t_out res;
        int             slot;
        logic [8:0]     h;
        res = '0;
        res.customer_out = ev.customer;
        if (ev.customer < CUSTOMER_COUNT) begin
            if (ev.action == lfra_pkg::ACT_ARRIVE) begin
                slot = ROOM_COUNT;
                for (int r = ROOM_COUNT - 1; r >= 0; r--) begin
                    if (vacant[r]) slot = r;
                end
                if (slot < ROOM_COUNT) begin
                    vacant[slot] = 1'b0;
                    res.room = 9'(slot + 1);
                    room_of[ev.customer] = 9'(slot + 1);
                    rooms_busy = rooms_busy + 9'd1;
                    if (rooms_busy > busiest) busiest = rooms_busy;
                end else begin
                    res.no_room = 1'b1;
                end
            end else begin
                h = room_of[ev.customer];
                if (h >= 1 && h <= ROOM_COUNT && !vacant[h - 9'd1]) begin
                    vacant[h - 9'd1] = 1'b1;
                    room_of[ev.customer] = '0;
                    if (rooms_busy > 0) rooms_busy = rooms_busy - 9'd1;
                    res.room = h;
                end
            end
        end
        res.occupancy      = rooms_busy;
        res.peak_occupancy = busiest;
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        lfra_pkg::t_out want;
        if (!i_rst_n) begin
            vacant     = '1;
            rooms_busy = '0;
            busiest    = '0;
            booking_q.delete();
            o_outstanding = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                booking_q.insert(booking_q.size(), settle_event(i_in_data));
                o_outstanding++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (booking_q.size() == 0) begin
                    $error("unexpected transaction: room %0d customer %0d",
                           i_out_data.room, i_out_data.customer_out);
                    o_mismatches++;
                end else begin
                    want = booking_q.pop_front();
                    o_outstanding--;
                    check_field("room", want.room, i_out_data.room);
                    check_field("customer_out", want.customer_out, i_out_data.customer_out);
                    check_field("occupancy", want.occupancy, i_out_data.occupancy);
                    check_field("peak_occupancy", want.peak_occupancy,
                                i_out_data.peak_occupancy);
                    check_field("no_room", want.no_room, i_out_data.no_room);
                end
            end
        end
    end

endmodule

[test/lowest_free_room_allocator_tb.sv]
`timescale 1ns / 100ps

module lowest_free_room_allocator_tb;

    localparam int ROOMS         = 256;
    localparam int CUSTOMERS     = 256;
    localparam int RANDOM_EVENTS = 1800;
    localparam int QUIET_TAIL    = 200;
    localparam int LEAK_CAP      = 12;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum {PICK_HOLDER, PICK_NEWCOMER, PICK_LAPSED} t_pick;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           out_stall = 1'b0;
    lfra_pkg::t_in  in_data   = '0;
    logic           in_stall;
    logic           out_valid;
    lfra_pkg::t_out out_data;
    int             mismatches;
    int             outstanding;

    // stimulus-side view of who holds a room, used only to shape the traffic
    bit holds   [CUSTOMERS];
    bit touched [CUSTOMERS];
    int rooms_taken = 0;
    int leaks       = 0;
    int n_arrive    = 0;
    int n_depart    = 0;
    int n_full      = 0;
    int n_empty_dep = 0;
    int cyc         = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lowest_free_room_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    lfra_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic bit calm_stretch();
        return ((cyc / 300) % 4) == 2;
    endfunction

    // output-side stall bursts
    always @(negedge clk) begin
        cyc++;
        if (quiet || calm_stretch()) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic int pick(t_pick kind);
        int start;
        int c;
        start = $urandom_range(0, CUSTOMERS - 1);
        for (int k = 0; k < CUSTOMERS; k++) begin
            c = (start + k) % CUSTOMERS;
            case (kind)
                PICK_HOLDER:   if (holds[c]) return c;
                PICK_NEWCOMER: if (!holds[c]) return c;
                PICK_LAPSED:   if (touched[c] && !holds[c]) return c;
                default:       return -1;
            endcase
        end
        return -1;
    endfunction

    task automatic issue(logic act, int cust);
        lfra_pkg::t_in ev;
        int            gap;
        ev.action   = act;
        ev.customer = cust[7:0];
        if (act == lfra_pkg::ACT_ARRIVE) begin
            n_arrive++;
            if (rooms_taken < ROOMS) begin
                rooms_taken++;
                if (holds[cust]) leaks++;
                holds[cust]   = 1'b1;
                touched[cust] = 1'b1;
            end else begin
                n_full++;
            end
        end else begin
            n_depart++;
            if (holds[cust]) begin
                holds[cust] = 1'b0;
                rooms_taken--;
            end else begin
                n_empty_dep++;
            end
        end
        if (!quiet && !calm_stretch() && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, outstanding);
        $display("** lowest_free_room_allocator: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int target;
        int span;
        int r;
        int c;
        int random_sent;
        bit arrive;
        phase       = 0;
        random_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: edge customers, repeat arrival of a holder,
        // departure with no record, reuse of the lowest freed room
        issue(lfra_pkg::ACT_ARRIVE, 0);
        issue(lfra_pkg::ACT_ARRIVE, 255);
        issue(lfra_pkg::ACT_ARRIVE, 0);
        issue(lfra_pkg::ACT_DEPART, 0);
        issue(lfra_pkg::ACT_DEPART, 0);
        issue(lfra_pkg::ACT_ARRIVE, 170);
        issue(lfra_pkg::ACT_DEPART, 255);
        issue(lfra_pkg::ACT_ARRIVE, 85);
        issue(lfra_pkg::ACT_ARRIVE, 1);
        issue(lfra_pkg::ACT_DEPART, 170);
        issue(lfra_pkg::ACT_ARRIVE, 254);
        issue(lfra_pkg::ACT_DEPART, 85);
        issue(lfra_pkg::ACT_DEPART, 1);
        issue(lfra_pkg::ACT_DEPART, 254);
        issue(lfra_pkg::ACT_DEPART, 255);

        // random phases walk occupancy toward a target; some fill every room
        while (random_sent < RANDOM_EVENTS) begin
            phase++;
            if (phase % 5 == 2 || $urandom_range(0, 7) == 0) begin
                target = ROOMS + 1;
                span   = 520;
            end else begin
                target = $urandom_range(0, ROOMS * 3 / 4);
                span   = $urandom_range(40, 160);
            end
            for (int k = 0; k < span && random_sent < RANDOM_EVENTS; k++) begin
                if (random_sent == RANDOM_EVENTS - QUIET_TAIL) quiet = 1'b1;
                r = $urandom_range(0, 99);
                c = -1;
                arrive = 1'b1;
                if (r < 6) begin
                    if (r < 3 && leaks < LEAK_CAP) begin
                        c = pick(PICK_HOLDER);
                        arrive = 1'b1;
                    end else begin
                        c = pick(PICK_LAPSED);
                        arrive = 1'b0;
                    end
                end
                if (c < 0) begin
                    arrive = ((rooms_taken < target) == ($urandom_range(0, 99) < 82));
                    if (!arrive) c = pick(PICK_HOLDER);
                    if (c < 0) begin
                        arrive = 1'b1;
                        c = pick(PICK_NEWCOMER);
                        if (c < 0) c = $urandom_range(0, CUSTOMERS - 1);
                    end
                end
                issue(arrive ? lfra_pkg::ACT_ARRIVE : lfra_pkg::ACT_DEPART, c);
                random_sent++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (24) @(posedge clk);

        $display("covered %0d arrivals (%0d with every room taken) and %0d departures",
                 n_arrive, n_full, n_depart);
        $display("departures without a record: %0d, rooms lost to repeat arrivals: %0d",
                 n_empty_dep, leaks);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** lowest_free_room_allocator: PASSED **");
        end else begin
            $display("** lowest_free_room_allocator: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
src/lfra_pkg.sv
src/lfra_ram.sv
src/lfra_ctrl.sv
src/lfra_dp.sv
src/lowest_free_room_allocator.sv
test/lfra_checker.sv
test/lowest_free_room_allocator_tb.sv
